[rtl/swpr_pkg.sv]
// ---------------------------------------------------------------------------
// swpr_pkg: shared definitions for the sliding window peak rate block
// Ring geometry, field widths, status range and the structs passed between
// the sequencer, the ring memory and the top level.
// ---------------------------------------------------------------------------
package swpr_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(RING_DEPTH + 1);

   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 10;
   localparam int OUT_CNT_W  = 11;
   localparam int TALLY_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [STATUS_W-1:0] ERR_LOW  = STATUS_W'(500);
   localparam logic [STATUS_W-1:0] ERR_HIGH = STATUS_W'(599);

   // Register byte address of window_seconds.
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW = '0;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [TIME_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } swpr_mem_req_type;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] window_count;
      logic [OUT_CNT_W-1:0] peak_count;
      logic [TIME_W-1:0]    peak_start;
      logic [TIME_W-1:0]    peak_end;
      logic [TALLY_W-1:0]   server_error_count;
      logic                 overflowed;
   } swpr_result_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
      return nxt;
   endfunction

endpackage

[rtl/swpr_if.sv]
// ---------------------------------------------------------------------------
// swpr_if: item channels of the sliding window peak rate block
// Event channel and result channel, each a valid/ready pair with payload.
// ---------------------------------------------------------------------------
interface swpr_req_if import swpr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   event_time;
   logic [STATUS_W-1:0] status_code;

   modport source (output valid, output event_time, output status_code, input ready);
   modport sink   (input valid, input event_time, input status_code, output ready);
endinterface

interface swpr_rsp_if import swpr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_CNT_W-1:0] window_count;
   logic [OUT_CNT_W-1:0] peak_count;
   logic [TIME_W-1:0]    peak_start;
   logic [TIME_W-1:0]    peak_end;
   logic [TALLY_W-1:0]   server_error_count;
   logic                 overflowed;

   modport source (output valid, output window_count, output peak_count,
                   output peak_start, output peak_end, output server_error_count,
                   output overflowed, input ready);
   modport sink   (input valid, input window_count, input peak_count,
                   input peak_start, input peak_end, input server_error_count,
                   input overflowed, output ready);
endinterface

[rtl/swpr_ring.sv]
// ---------------------------------------------------------------------------
// swpr_ring: timestamp ring storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module swpr_ring import swpr_pkg::*; (
   input  logic              clock,
   input  swpr_mem_req_type  mem_req,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [RING_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/swpr_span_cmp.sv]
// ---------------------------------------------------------------------------
// swpr_span_cmp: shared span compare unit
// Computes newest minus oldest modulo 2^32 and flags spans above the window.
// ---------------------------------------------------------------------------
module swpr_span_cmp import swpr_pkg::*; (
   input  logic [TIME_W-1:0] newest,
   input  logic [TIME_W-1:0] oldest,
   input  logic [TIME_W-1:0] window,
   output logic              drop
);

   logic [TIME_W-1:0] span;

   // Wraparound is intended: an out-of-order timestamp gives a huge span.
   assign span = newest - oldest;
   assign drop = (span > window);

endmodule

[rtl/swpr_seq.sv]
// ---------------------------------------------------------------------------
// swpr_seq: window sequencer
// Pushes each event into the ring, then pops old entries one compare at a
// time through the shared span unit, and finally updates the peak record.
// ---------------------------------------------------------------------------
module swpr_seq import swpr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [TIME_W-1:0]   in_time,
   input  logic [STATUS_W-1:0] in_status,
   input  logic [TIME_W-1:0]   window,
   output swpr_mem_req_type    mem_req,
   input  logic [TIME_W-1:0]   rd_data,
   input  logic                drop,
   output logic [TIME_W-1:0]   cmp_newest,
   output logic [TIME_W-1:0]   cmp_oldest,
   output logic [TIME_W-1:0]   cmp_window,
   input  logic                out_free,
   output logic                done,
   output swpr_result_type     result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]         state_ff,  state_in;
   logic [TIME_W-1:0]  t_ff,      t_in;
   logic [TIME_W-1:0]  oldest_ff, oldest_in;
   logic [IDX_W-1:0]   head_ff,   head_in;
   logic [IDX_W-1:0]   tail_ff,   tail_in;
   logic [COUNT_W-1:0] live_ff,   live_in;
   logic [COUNT_W-1:0] best_ff,   best_in;
   logic [TIME_W-1:0]  first_ff,  first_in;
   logic [TIME_W-1:0]  last_ff,   last_in;
   logic [TALLY_W-1:0] tally_ff,  tally_in;
   logic               ovf_ff,    ovf_in;

   logic               accept;
   logic               full;
   logic               is_err;
   logic               better;

   assign in_ready   = (state_ff == ST_IDLE);
   assign accept     = in_valid && in_ready;
   assign full       = (live_ff == COUNT_W'(RING_DEPTH));
   assign is_err     = (in_status >= ERR_LOW) && (in_status <= ERR_HIGH);
   assign better     = (live_ff > best_ff);

   assign cmp_newest = t_ff;
   assign cmp_oldest = rd_data;
   assign cmp_window = window;

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      oldest_in = oldest_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      live_in   = live_ff;
      best_in   = best_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      tally_in  = tally_ff;
      ovf_in    = ovf_ff;
      done      = 1'b0;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = tail_ff;
      mem_req.wr_data = in_time;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               t_in = in_time;
               if (is_err && (tally_ff != '1)) begin
                  tally_in = tally_ff + 1'b1;
               end
               // A full ring loses its oldest entry; the new one overwrites it.
               if (full) begin
                  head_in = ring_next(head_ff);
                  ovf_in  = 1'b1;
                  live_in = live_ff;
               end else begin
                  live_in = live_ff + 1'b1;
               end
               mem_req.wr_en = 1'b1;
               tail_in       = ring_next(tail_ff);
               if (live_in > COUNT_W'(1)) begin
                  state_in = ST_LOAD;
               end else begin
                  oldest_in = in_time;
                  state_in  = ST_FIN;
               end
            end
         end
         ST_LOAD: begin
            mem_req.rd_en = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (drop) begin
               head_in = ring_next(head_ff);
               live_in = live_ff - 1'b1;
               if (live_ff == COUNT_W'(2)) begin
                  // Only the newest entry is left.
                  oldest_in = t_ff;
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_LOAD;
               end
            end else begin
               oldest_in = rd_data;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               done = 1'b1;
               if (better) begin
                  best_in  = live_ff;
                  first_in = oldest_ff;
                  last_in  = t_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.window_count       = OUT_CNT_W'(live_ff);
      result.peak_count         = OUT_CNT_W'(best_in);
      result.peak_start         = first_in;
      result.peak_end           = last_in;
      result.server_error_count = tally_ff;
      result.overflowed         = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         live_ff  <= '0;
         best_ff  <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         tally_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         live_ff  <= live_in;
         best_ff  <= best_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         tally_ff <= tally_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      oldest_ff <= oldest_in;
   end

endmodule

[rtl/sliding_window_peak_rate.sv]
// An event whose window holds only the new entry needs no compare; otherwise
// old entries are popped one compare at a time, each through the single span
// compare unit after a ring read, until an older one stays or all are gone.
// A stalled result side adds its wait; a new event waits for the last one.
// Reset (synchronous, active high) empties the window, clears the peak,
// the error tally, the overflow flag and window_seconds; no clearing pass.
// ---------------------------------------------------------------------------
// sliding_window_peak_rate: peak event count over a sliding time window
// Keeps event timestamps in a ring, trims entries older than the window,
// and reports the window count, the earliest peak and a server error tally.
// ---------------------------------------------------------------------------
module sliding_window_peak_rate import swpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swpr_req_if.sink              req_if,
   swpr_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TIME_W-1:0] window_ff;
   logic              csr_wr;

   swpr_mem_req_type  mem_req;
   logic [TIME_W-1:0] rd_data;
   logic [TIME_W-1:0] cmp_newest;
   logic [TIME_W-1:0] cmp_oldest;
   logic [TIME_W-1:0] cmp_window;
   logic              drop;
   logic              out_free;
   logic              done;
   swpr_result_type   result;

   logic              rsp_valid_ff;
   swpr_result_type   rsp_data_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == REG_WINDOW) ? window_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (csr_wr && (csr_paddr[CSR_ADDR_W-1] == 1'b0)) begin
         window_ff <= csr_pwdata;
      end
   end

   swpr_ring u_ring (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   swpr_span_cmp u_span (
      .newest (cmp_newest),
      .oldest (cmp_oldest),
      .window (cmp_window),
      .drop   (drop)
   );

   swpr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_time    (req_if.event_time),
      .in_status  (req_if.status_code),
      .window     (window_ff),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .drop       (drop),
      .cmp_newest (cmp_newest),
      .cmp_oldest (cmp_oldest),
      .cmp_window (cmp_window),
      .out_free   (out_free),
      .done       (done),
      .result     (result)
   );

   // Result register: the next item may be worked on while this one waits.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.window_count       = rsp_data_ff.window_count;
   assign rsp_if.peak_count         = rsp_data_ff.peak_count;
   assign rsp_if.peak_start         = rsp_data_ff.peak_start;
   assign rsp_if.peak_end           = rsp_data_ff.peak_end;
   assign rsp_if.server_error_count = rsp_data_ff.server_error_count;
   assign rsp_if.overflowed         = rsp_data_ff.overflowed;

endmodule
